FILE: sv/tws_pkg.sv
package tws_pkg;

    // Default size of the whitespace hold store
    localparam int PENDING_DEPTH = 63;

    // Byte codes the filter reacts to
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // One kind bit per held whitespace byte
    localparam logic KIND_SPACE = 1'b0;
    localparam logic KIND_TAB   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // capture the incoming byte
        logic push;      // append the incoming whitespace byte to the store
        logic rd_head;   // read the oldest held byte
        logic ovf_load;  // send the oldest byte early and append the captured byte
        logic rel_load;  // send the oldest byte as part of a release and drop it
        logic load_char; // send the captured byte as the last transfer of the item
        logic clear_run; // discard every held byte
        logic set_text;  // mark that the current line has sent output
        logic clr_text;  // start a fresh line
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_ws;     // incoming byte is a space or a tab
        logic is_nl;     // incoming byte is a newline
        logic full;      // store holds its full depth
        logic empty;     // store holds nothing
        logic has_text;  // current line has sent output
        logic out_free;  // output register can take a new transfer this cycle
    } status_t;

    function automatic logic [7:0] kind_to_char(input logic kind);
        return (kind == KIND_TAB) ? CH_TAB : CH_SPACE;
    endfunction

    function automatic logic char_to_kind(input logic [7:0] ch);
        return (ch == CH_TAB) ? KIND_TAB : KIND_SPACE;
    endfunction

endpackage

FILE: sv/tws_ram.sv
module tws_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port that holds between reads.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/tws_datapath.sv
module tws_datapath #(
    parameter int DEPTH = tws_pkg::PENDING_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tws_pkg::cmd_t     cmd,
    output tws_pkg::status_t  status,
    input  logic [7:0]        s_in_char,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_char,
    output logic              m_last_of_run,
    output logic              m_overflow
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          text_reg, text_next;
    logic [7:0]    char_reg;
    logic          valid_reg, valid_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          last_reg, last_next;
    logic          ovf_reg, ovf_next;
    logic          ram_wr_en;
    logic          ram_wr_data;
    logic          ram_rd_data;
    logic          load;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // The hold store is a circular buffer of kind bits.
    assign ram_wr_en   = cmd.push | cmd.ovf_load;
    assign ram_wr_data = cmd.push ? tws_pkg::char_to_kind(s_in_char)
                                  : tws_pkg::char_to_kind(char_reg);

    tws_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_head),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // Status toward the controller.
    assign status.is_ws    = (s_in_char == tws_pkg::CH_SPACE) || (s_in_char == tws_pkg::CH_TAB);
    assign status.is_nl    = (s_in_char == tws_pkg::CH_NEWLINE);
    assign status.full     = (count_reg == CW'(DEPTH));
    assign status.empty    = (count_reg == '0);
    assign status.has_text = text_reg;
    assign status.out_free = !valid_reg || m_ready;

    // Pointer, count and line flag updates.
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        text_next  = text_reg;
        if (cmd.push) begin
            tail_next  = ptr_inc(tail_reg);
            count_next = count_reg + CW'(1);
        end
        if (cmd.ovf_load) begin
            head_next = ptr_inc(head_reg);
            tail_next = ptr_inc(tail_reg);
        end
        if (cmd.rel_load) begin
            head_next  = ptr_inc(head_reg);
            count_next = count_reg - CW'(1);
        end
        if (cmd.clear_run) begin
            head_next  = tail_reg;
            count_next = '0;
        end
        if (cmd.set_text) begin
            text_next = 1'b1;
        end
        if (cmd.clr_text) begin
            text_next = 1'b0;
        end
    end

    // Output register: loaded from the store or from the captured byte.
    assign load = cmd.ovf_load | cmd.rel_load | cmd.load_char;

    always_comb begin
        out_char_next = out_char_reg;
        last_next     = last_reg;
        ovf_next      = ovf_reg;
        valid_next    = valid_reg && !m_ready;
        if (load) begin
            valid_next = 1'b1;
        end
        if (cmd.ovf_load || cmd.rel_load) begin
            out_char_next = tws_pkg::kind_to_char(ram_rd_data);
            last_next     = cmd.ovf_load;
            ovf_next      = cmd.ovf_load;
        end else if (cmd.load_char) begin
            out_char_next = char_reg;
            last_next     = 1'b1;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            text_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            text_reg  <= text_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            char_reg <= s_in_char;
        end
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        ovf_reg      <= ovf_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_char    = out_char_reg;
    assign m_last_of_run = last_reg;
    assign m_overflow    = ovf_reg;

endmodule

FILE: sv/tws_ctrl.sv
module tws_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tws_pkg::status_t  status,
    output tws_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OVF_SEND,
        ST_REL_READ,
        ST_REL_SEND,
        ST_LAST
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.is_ws) begin
                        if (!status.full) begin
                            cmd.push = 1'b1;
                        end else begin
                            cmd.rd_head  = 1'b1;
                            cmd.set_text = 1'b1;
                            state_next   = ST_OVF_SEND;
                        end
                    end else if (status.is_nl) begin
                        cmd.clear_run = 1'b1;
                        if (status.has_text) begin
                            cmd.clr_text = 1'b1;
                            state_next   = ST_LAST;
                        end
                    end else begin
                        cmd.set_text = 1'b1;
                        state_next   = ST_REL_READ;
                    end
                end
            end
            ST_OVF_SEND: begin
                if (status.out_free) begin
                    cmd.ovf_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_REL_READ: begin
                if (status.empty) begin
                    state_next = ST_LAST;
                end else begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_REL_SEND;
                end
            end
            ST_REL_SEND: begin
                if (status.out_free) begin
                    cmd.rel_load = 1'b1;
                    state_next   = ST_REL_READ;
                end
            end
            ST_LAST: begin
                if (status.out_free) begin
                    cmd.load_char = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/trailing_whitespace_stripper.sv
// Trailing whitespace and blank line stripper.
// Input channel s_*: one text byte per transfer on s_in_char. Result channel m_*:
// one filtered byte per transfer on m_out_char, with m_last_of_run high on the
// final transfer caused by an input byte and m_overflow high when a held space
// or tab is sent early because the hold store is full.
// Spaces and tabs are held in a circular store (one kind bit each, in a RAM)
// until a text byte releases them; a newline discards them and is only passed
// on when its line carried output.
// A space or tab that fits in the store, or a newline on an empty line, is taken
// without output. A text byte releases the held bytes one at a time, each read
// through the registered read port of the store before it is sent.
// Reset (aresetn, synchronous, active low) empties the store, clears the line
// flag and the output valid flag; it needs no clearing pass.
// When the receiver stalls, the output register holds its transfer and the
// controller waits; s_ready stays low until the current input byte is done.
module trailing_whitespace_stripper #(
    parameter int PENDING_DEPTH = tws_pkg::PENDING_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_of_run,
    output logic       m_overflow
);

    tws_pkg::cmd_t    cmd;
    tws_pkg::status_t status;

    // Sequencing of one input byte.
    tws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold store, line flag and output register.
    tws_datapath #(
        .DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_in_char     (s_in_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_of_run (m_last_of_run),
        .m_overflow    (m_overflow)
    );

endmodule
